@@ hdl/dque_pkg.sv @@
// Shared operation codes, status codes, cell commands and types for the deque ring.
package dque_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_TRAVERSE   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_IN,
      CELL_WRITE_BACK,
      CELL_SHIFT_OUT,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [DATA_W-1:0]   push_value;
   } cell_ctrl_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_WALK
   } fsm_state_type;

endpackage

@@ hdl/dque_cell.sv @@
// One storage cell of the deque row; it moves its value to or from its neighbors.
module dque_cell #(
   parameter int CNT_W = 6,
   parameter int IDX   = 0
) (
   input  logic                          clock,
   input  dque_pkg::cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]              count,
   input  logic [dque_pkg::DATA_W-1:0]   left_val,
   input  logic [dque_pkg::DATA_W-1:0]   right_val,
   input  logic [dque_pkg::DATA_W-1:0]   wrap_val,
   output logic [dque_pkg::DATA_W-1:0]   val,
   output logic [dque_pkg::DATA_W-1:0]   tail_val
);
   import dque_pkg::*;

   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] val_in;
   logic              is_free_slot;
   logic              is_last;

   // The first free slot sits at index count; the back entry just below it.
   assign is_free_slot = (count == CNT_W'(IDX));
   assign is_last      = (count == CNT_W'(IDX + 1));

   always_comb begin
      val_in = val_ff;
      unique case (ctrl.cmd)
         CELL_HOLD:       val_in = val_ff;
         CELL_SHIFT_IN:   val_in = left_val;
         CELL_WRITE_BACK: val_in = is_free_slot ? ctrl.push_value : val_ff;
         CELL_SHIFT_OUT:  val_in = right_val;
         CELL_ROTATE:     val_in = is_last ? wrap_val : right_val;
         default:         val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val      = val_ff;
   assign tail_val = is_last ? val_ff : '0;

endmodule

@@ hdl/double_ended_queue_ring.sv @@
// Top level of the bounded double-ended queue built as a row of shifting cells.
//
// Usage: drive req_op and req_value with start high; the operation is taken at
// a clock edge where start is high and busy is low. Operations are push back,
// push front, pop front, pop back and traverse. Each result appears on rsp_item,
// rsp_status and rsp_last for exactly one cycle with rsp_valid high; the
// receiver must take it then, since it cannot stall the block.
// The queue is held in order in a row of CAPACITY cells: the front entry is
// always in cell 0. Push front and pop front shift the whole row by one cell,
// push back writes the first free cell, and pop back reads the back cell.
// A push or pop gives a single registered result in the cycle after the
// transfer, and busy stays low, so one push or pop is taken every cycle.
// Traverse of N stored entries rotates the occupied cells once per cycle,
// giving one result per cycle from the front. The transfer enters the walk
// state; each result is registered from cell 0, and busy is high for the walk,
// so the next operation waits for its end. The rotation leaves the order intact.
// A traverse or pop on an empty queue gives one result with status empty.
// Reset empties the queue and aborts a traverse; cell contents are not cleared.
module double_ended_queue_ring #(
   parameter int CAPACITY = dque_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dque_pkg::OP_W-1:0]           req_op,
   input  logic signed [dque_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [dque_pkg::DATA_W-1:0]  rsp_item,
   output logic [dque_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_last
);
   import dque_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   fsm_state_type         state_ff;
   fsm_state_type         state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      remain_ff;
   logic [IDX_W-1:0]      remain_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_W-1:0]     rsp_item_ff;
   logic [DATA_W-1:0]     rsp_item_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;

   cell_ctrl_type         cell_ctrl;
   logic [DATA_W-1:0]     cell_val  [CAPACITY];
   logic [DATA_W-1:0]     cell_tail [CAPACITY];
   logic [DATA_W-1:0]     tail_any;
   logic                  accept;
   logic                  is_empty;
   logic                  is_full;

   assign busy     = (state_ff == FSM_WALK);
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));

   // The row of cells. Cell 0 takes the pushed value on a front shift, the
   // last cell takes zero on a front pop, and the back entry wraps to cell 0's
   // value during a traverse rotation.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_inner_left
         assign left_v = cell_val[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_inner_right
         assign right_v = cell_val[g+1];
      end
      dque_cell #(
         .CNT_W (CNT_W),
         .IDX   (g)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .count     (count_ff),
         .left_val  (left_v),
         .right_val (right_v),
         .wrap_val  (cell_val[0]),
         .val       (cell_val[g]),
         .tail_val  (cell_tail[g])
      );
   end

   // Only the back cell drives a nonzero tail value, so an OR collects it.
   always_comb begin
      tail_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_any = tail_any | cell_tail[i];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_op == OP_TRAVERSE) && !is_empty) begin
               state_in = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (remain_ff == '0) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Cell commands, fill count and the next result.
   always_comb begin
      cell_ctrl.cmd        = CELL_HOLD;
      cell_ctrl.push_value = req_value;
      count_in             = count_ff;
      remain_in            = remain_ff;
      rsp_valid_in         = 1'b0;
      rsp_item_in          = '0;
      rsp_status_in        = STAT_OK;
      rsp_last_in          = 1'b1;
      if (state_ff == FSM_WALK) begin
         // The front entry is emitted, then the occupied cells rotate left.
         rsp_valid_in  = 1'b1;
         rsp_item_in   = cell_val[0];
         rsp_last_in   = (remain_ff == '0);
         cell_ctrl.cmd = CELL_ROTATE;
         remain_in     = remain_ff - 1'b1;
      end else if (accept) begin
         unique case (req_op)
            OP_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  cell_ctrl.cmd = CELL_WRITE_BACK;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  cell_ctrl.cmd = CELL_SHIFT_IN;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_item_in   = cell_val[0];
                  cell_ctrl.cmd = CELL_SHIFT_OUT;
                  count_in      = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_item_in = tail_any;
                  count_in    = count_ff - 1'b1;
               end
            end
            OP_TRAVERSE: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  remain_in = IDX_W'(count_ff - 1'b1);
               end
            end
            default: begin
               // Unused operation codes are dropped without a result.
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // A traverse only runs over a queue that holds something.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WALK) |-> (count_ff != '0))
      else $error("traverse running on an empty queue");

   // The fill count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(CAPACITY)))
      else $error("fill count beyond capacity");

   // A traverse leaves the fill count untouched.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WALK) |=> $stable(count_ff))
      else $error("fill count changed during traverse");

   // Error results are always single and the last of their operation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_last_ff && (rsp_item_ff == '0)))
      else $error("error result not final or carries data");

   // The final traverse result is given as the walk ends.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_WALK) && (remain_ff == '0)) |=> (rsp_valid_ff && rsp_last_ff && !busy))
      else $error("traverse did not finish with a final result");

endmodule

@@ tb/sv/tb_double_ended_queue_ring.sv @@
// Self-checking testbench for the double-ended queue ring with a shadow deque scoreboard.
module tb_double_ended_queue_ring;
   import dque_pkg::*;

   // The block is built with its default depth; the shadow deque uses the same one.
   localparam int DEPTH = DEFAULT_CAPACITY;

   // Number of input items the random part aims for, in addition to the directed part.
   localparam int RANDOM_ITEMS = 270;

   // A traverse of a full queue gives DEPTH results. The drain period after the final
   // expected response is much longer than such a traverse, so a stray response from an
   // ignored op code would still be seen.
   localparam int DRAIN_CYCLES = 4 * DEPTH;

   // The longest correct quiet stretch during traffic is a sender gap. The watchdog
   // limit is far above that and also above the drain period at the end.
   localparam int WATCHDOG_LIMIT = 2000;

   // One response transfer as it appears on the rsp_ ports.
   typedef struct {
      logic signed [DATA_W-1:0] item;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_fields_type;

   // Shadow deque. It keeps its own copy of the ring, front index and fill count,
   // works out the responses of every accepted operation and checks the responses
   // that the block produces against them in order.
   class deque_shadow;
      logic signed [DATA_W-1:0] ring [DEPTH];
      int unsigned              front_idx;
      int unsigned              fill;
      rsp_fields_type           awaited[$];
      int                       mismatches;

      function new();
         front_idx  = 0;
         fill       = 0;
         mismatches = 0;
      endfunction

      function void add_rsp(logic signed [DATA_W-1:0] item, logic [STATUS_W-1:0] status,
                            logic last);
         rsp_fields_type r;
         r.item   = item;
         r.status = status;
         r.last   = last;
         awaited.push_back(r);
      endfunction

      // Called for every operation that the block accepts.
      function void record_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
         int unsigned slot_idx;
         case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (fill >= DEPTH) begin
                  // A push on a full queue is dropped and reported as such.
                  add_rsp('0, STAT_FULL, 1'b1);
               end else begin
                  if (op == OP_PUSH_BACK) begin
                     ring[(front_idx + fill) % DEPTH] = value;
                  end else begin
                     front_idx = (front_idx + DEPTH - 1) % DEPTH;
                     ring[front_idx] = value;
                  end
                  fill++;
                  add_rsp('0, STAT_OK, 1'b1);
               end
            end
            OP_POP_FRONT: begin
               if (fill == 0) begin
                  add_rsp('0, STAT_EMPTY, 1'b1);
               end else begin
                  add_rsp(ring[front_idx], STAT_OK, 1'b1);
                  front_idx = (front_idx + 1) % DEPTH;
                  fill--;
               end
            end
            OP_POP_BACK: begin
               if (fill == 0) begin
                  add_rsp('0, STAT_EMPTY, 1'b1);
               end else begin
                  slot_idx = (front_idx + fill - 1) % DEPTH;
                  add_rsp(ring[slot_idx], STAT_OK, 1'b1);
                  fill--;
               end
            end
            OP_TRAVERSE: begin
               if (fill == 0) begin
                  add_rsp('0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++) begin
                     add_rsp(ring[(front_idx + i) % DEPTH], STAT_OK, (i + 1 == fill));
                  end
               end
            end
            default: begin
               // Unused op codes leave the queue alone and give no response.
            end
         endcase
      endfunction

      // Called for every response transfer; compares it with the oldest awaited one.
      function void check_response(logic signed [DATA_W-1:0] item, logic [STATUS_W-1:0] status,
                                   logic last);
         rsp_fields_type exp_rsp;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: response with none awaited: item=%0d status=%0d last=%0b",
                     $time, item, status, last);
            return;
         end
         exp_rsp = awaited.pop_front();
         if (item !== exp_rsp.item || status !== exp_rsp.status || last !== exp_rsp.last) begin
            mismatches++;
            $display("%0t: mismatch: expected item=%0d status=%0d last=%0b,",
                     $time, exp_rsp.item, exp_rsp.status, exp_rsp.last,
                     " got item=%0d status=%0d last=%0b", item, status, last);
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_op;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_item;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_last;

   deque_shadow shadow = new();

   int stall_cycles;
   int burst_left;
   int items_sent;

   double_ended_queue_ring #(
      .CAPACITY (DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor and watchdog. Everything here samples at the rising edge, and all inputs
   // are driven with nonblocking assignments at that edge, so the values seen are the
   // ones that held during the cycle that the edge ends. An operation transfer is an
   // edge with start high and busy low; a response transfer is an edge with rsp_valid
   // high, since the receiver can never hold a response off.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && busy === 1'b0) begin
            shadow.record_request(req_op, req_value);
         end
         if (rsp_valid === 1'b1) begin
            shadow.check_response(rsp_item, rsp_status, rsp_last);
         end
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("double_ended_queue_ring test failed");
            $finish;
         end
      end
   end

   // Presents one operation and holds it until the block takes it. The sender works in
   // bursts: when a burst runs out, start drops for a random gap while the request
   // ports carry noise that the block must ignore. Most bursts are short, so gaps land
   // on every phase of a traverse; some are long stretches with no gap at all.
   task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start     <= 1'b0;
         req_op    <= OP_W'($urandom);
         req_value <= $urandom;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Fills the queue from any state: more operations than the depth, nearly all pushes,
   // so the last ones can meet a full queue. A traverse now and then walks a long queue.
   task automatic fill_phase();
      int n;
      n = DEPTH + $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 19) == 0) begin
            send_op(OP_TRAVERSE, $urandom);
         end else begin
            send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
         end
      end
      send_op(OP_TRAVERSE, $urandom);
   endtask

   // Empties the queue from any state: more operations than the depth, nearly all pops.
   task automatic drain_phase();
      int n;
      n = DEPTH + $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 19) == 0) begin
            send_op(OP_TRAVERSE, $urandom);
         end else begin
            send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
         end
      end
   endtask

   // Mixed traffic around whatever fill level the queue has, with the odd unused
   // op code thrown in.
   task automatic mixed_phase();
      int n;
      int pick;
      n = $urandom_range(10, 40);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_op(OP_W'($urandom_range(5, 7)), $urandom);
         end else if (pick < 12) begin
            send_op(OP_TRAVERSE, $urandom);
         end else begin
            send_op(OP_W'($urandom_range(0, 3)), $urandom);
         end
      end
   endtask

   initial begin
      start      <= 1'b0;
      req_op     <= '0;
      req_value  <= '0;
      reset      <= 1'b1;
      items_sent = 0;
      burst_left = $urandom_range(1, 12);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every operation on an empty queue, the extreme values at both
      // ends, the unused op codes, and wrap of the front index below slot zero.
      send_op(OP_TRAVERSE,   32'sd0);
      send_op(OP_POP_FRONT,  32'sd0);
      send_op(OP_POP_BACK,   32'sd0);
      send_op(OP_PUSH_BACK,  32'sh7FFF_FFFF);
      send_op(OP_PUSH_FRONT, 32'sh8000_0000);
      send_op(OP_PUSH_BACK,  -32'sd1);
      send_op(OP_PUSH_FRONT, 32'sd0);
      send_op(OP_TRAVERSE,   32'sd0);
      send_op(3'd5,          32'sh1234_5678);
      send_op(3'd6,          -32'sd1);
      send_op(3'd7,          32'sh7FFF_FFFF);
      send_op(OP_POP_FRONT,  32'sd0);
      send_op(OP_POP_BACK,   -32'sd1);
      send_op(OP_POP_FRONT,  32'sd0);
      send_op(OP_POP_BACK,   32'sd0);
      send_op(OP_POP_BACK,   32'sd0);
      send_op(OP_PUSH_FRONT, 32'sh5555_5555);
      send_op(OP_PUSH_FRONT, 32'shAAAA_AAAA);
      send_op(OP_TRAVERSE,   32'sd0);
      send_op(OP_POP_BACK,   32'sd0);
      send_op(OP_POP_BACK,   32'sd0);
      send_op(OP_TRAVERSE,   32'sd0);

      // Random part. It opens with a fill and a drain, each of more operations than the
      // depth, to aim at the full and empty cases, then picks phases at random.
      items_sent = 0;
      fill_phase();
      drain_phase();
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       fill_phase();
            1:       drain_phase();
            default: mixed_phase();
         endcase
      end
      start <= 1'b0;

      // Wait for every awaited response, then a while longer to catch strays.
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("double_ended_queue_ring test passed");
      end else begin
         $display("double_ended_queue_ring test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/dque_pkg.sv
hdl/dque_cell.sv
hdl/double_ended_queue_ring.sv
tb/sv/tb_double_ended_queue_ring.sv
